// ===== sv/lufs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the LU factor-and-solve block.
package lufs_pkg;

  localparam int MAX_N     = 16;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IW        = $clog2(MAX_N);
  localparam int NW        = $clog2(MAX_N + 1);
  localparam int AW        = $clog2(MAX_N * MAX_N);
  localparam int PIW       = $clog2(MAX_N - 1);
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int CFG_IW    = 1;
  localparam int CFG_DW    = 16;
  localparam int MAG_W     = DATA_W + 1;

  localparam logic [CFG_IW-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IW-1:0] REG_ZERO_THR    = 1'b1;

  localparam logic CMD_MATRIX = 1'b0;
  localparam logic CMD_RHS    = 1'b1;

  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_SOLUTION = 1'b1;

  localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     kind;
    logic [IW-1:0]            index;
    logic signed [DATA_W-1:0] solution;
    logic                     singular;
    logic                     overflow;
    logic                     perm_negative;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] q;
    logic                     ovf;
  } div_rsp_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // Round half up, drop the fraction bits and saturate to the data width.
  function automatic sat_t mul_round_sat(input logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] s;
    logic signed [2*DATA_W-1:0] sh;
    sat_t r;
    s  = p + ({{(2*DATA_W-1){1'b0}}, 1'b1} <<< (FRAC_BITS - 1));
    sh = s >>> FRAC_BITS;
    if (sh > $signed({{DATA_W{1'b0}}, FX_MAX})) begin
      r.ovf = 1'b1;
      r.val = FX_MAX;
    end else if (sh < $signed({{DATA_W{1'b1}}, FX_MIN})) begin
      r.ovf = 1'b1;
      r.val = FX_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = sh[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sub_sat(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    sat_t r;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      r.ovf = 1'b1;
      r.val = d[DATA_W] ? FX_MIN : FX_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = d[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    logic [MAG_W-1:0] e;
    e = {v[DATA_W-1], v};
    return v[DATA_W-1] ? (~e + {{(MAG_W-1){1'b0}}, 1'b1}) : e;
  endfunction

endpackage

// ===== sv/lufs_div.sv =====
// Restoring fixed-point divider, one quotient bit per cycle, with saturation.
module lufs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lufs_pkg::div_req_t req_i,
  output lufs_pkg::div_rsp_t rsp_o
);

  localparam int CW = $clog2(lufs_pkg::DIV_W + 1);
  localparam int DW = lufs_pkg::DATA_W;

  logic                     run_q, run_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [lufs_pkg::DIV_W-1:0] num_q, num_d;
  logic [DW-1:0]            rem_q, rem_d;
  logic [DW-1:0]            den_q, den_d;
  logic                     neg_q, neg_d;
  logic                     done_q, done_d;
  logic signed [DW-1:0]     quo_q, quo_d;
  logic                     ovf_q, ovf_d;

  logic [DW-1:0]            mag_a, mag_b;
  logic [DW:0]              trial;
  logic                     qbit;
  logic [lufs_pkg::DIV_W-1:0] lim;

  always_comb begin
    mag_a = req_i.a[DW-1] ? (~req_i.a + 1'b1) : req_i.a;
    mag_b = req_i.b[DW-1] ? (~req_i.b + 1'b1) : req_i.b;
    trial = {rem_q, num_q[lufs_pkg::DIV_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    lim   = neg_q ? {{(lufs_pkg::DIV_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}}
                  : {{(lufs_pkg::DIV_W-DW+1){1'b0}}, {(DW-1){1'b1}}};

    run_d  = run_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    ovf_d  = ovf_q;

    if (req_i.start) begin
      if (req_i.b == '0) begin
        done_d = 1'b1;
        ovf_d  = 1'b1;
        quo_d  = req_i.a[DW-1] ? lufs_pkg::FX_MIN : lufs_pkg::FX_MAX;
      end else begin
        run_d = 1'b1;
        cnt_d = '0;
        num_d = {mag_a, {lufs_pkg::FRAC_BITS{1'b0}}};
        rem_d = '0;
        den_d = mag_b;
        neg_d = req_i.a[DW-1] ^ req_i.b[DW-1];
      end
    end else if (run_q) begin
      if (cnt_q == CW'(lufs_pkg::DIV_W)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        if (num_q > lim) begin
          ovf_d = 1'b1;
          quo_d = neg_q ? lufs_pkg::FX_MIN : lufs_pkg::FX_MAX;
        end else begin
          ovf_d = 1'b0;
          quo_d = neg_q ? -num_q[DW-1:0] : num_q[DW-1:0];
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
        rem_d = qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
        num_d = {num_q[lufs_pkg::DIV_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;
  assign rsp_o.ovf  = ovf_q;

endmodule

// ===== sv/lu_factor_and_solve.sv =====
// Top level of the LU factor-and-solve block: sequencer, matrix store and shared arithmetic.
//
// Usage. A beat is offered on in_i with start_i high and is taken at a rising edge where
// busy_o is low. Command 0 beats carry matrix elements in row-major order; the first one
// latches the order n from the matrix_size register (clamped to 2..16) and clears the
// overflow flag. Loading takes one cycle per element. After the n*n-th element the block
// raises busy_o and factors the matrix in place with partial pivoting. Per column i this
// means a pivot search, a row swap when one is needed, and for each row below the pivot
// a division by the 48-step divider and a multiply-subtract loop over the one matrix
// memory port. One status beat (kind 0) follows. Command 1 beats then load the
// right-hand side, one per cycle; after the n-th the block permutes it, runs forward and
// back substitution and emits the n solution beats, the final one marked last.
// Results appear on res_o for exactly one cycle with result_valid_o high; the receiver
// cannot stall them. Configuration writes are taken at any edge with cfg_we_i high and
// should be made only while the block is idle. Reset empties the sequencer and forgets
// any factorization; the stores are not cleared.
module lu_factor_and_solve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  lufs_pkg::in_t                 in_i,
  output logic                          result_valid_o,
  output lufs_pkg::out_t                res_o,
  input  logic                          cfg_we_i,
  input  logic [lufs_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [lufs_pkg::CFG_DW-1:0]   cfg_wdata_i
);

  localparam int IW  = lufs_pkg::IW;
  localparam int NW  = lufs_pkg::NW;
  localparam int AW  = lufs_pkg::AW;
  localparam int DW  = lufs_pkg::DATA_W;
  localparam int MW  = lufs_pkg::MAG_W;
  localparam int PIW = lufs_pkg::PIW;
  localparam int SW  = 5;

  localparam logic [SW-1:0] ST_IDLE    = 5'd0;
  localparam logic [SW-1:0] ST_PV_RD   = 5'd1;
  localparam logic [SW-1:0] ST_PV_EV   = 5'd2;
  localparam logic [SW-1:0] ST_PV_CHK  = 5'd3;
  localparam logic [SW-1:0] ST_SW_RD1  = 5'd4;
  localparam logic [SW-1:0] ST_SW_RD2  = 5'd5;
  localparam logic [SW-1:0] ST_SW_WR1  = 5'd6;
  localparam logic [SW-1:0] ST_SW_WR2  = 5'd7;
  localparam logic [SW-1:0] ST_EL_RD   = 5'd8;
  localparam logic [SW-1:0] ST_EL_GO   = 5'd9;
  localparam logic [SW-1:0] ST_EL_WT   = 5'd10;
  localparam logic [SW-1:0] ST_MAC_RD  = 5'd11;
  localparam logic [SW-1:0] ST_MAC_MUL = 5'd12;
  localparam logic [SW-1:0] ST_MAC_RND = 5'd13;
  localparam logic [SW-1:0] ST_MAC_SUB = 5'd14;
  localparam logic [SW-1:0] ST_EL_WF   = 5'd15;
  localparam logic [SW-1:0] ST_STATUS  = 5'd16;
  localparam logic [SW-1:0] ST_PM_CHK  = 5'd17;
  localparam logic [SW-1:0] ST_PM_RD1  = 5'd18;
  localparam logic [SW-1:0] ST_PM_RD2  = 5'd19;
  localparam logic [SW-1:0] ST_PM_WR1  = 5'd20;
  localparam logic [SW-1:0] ST_PM_WR2  = 5'd21;
  localparam logic [SW-1:0] ST_SV_BEG  = 5'd22;
  localparam logic [SW-1:0] ST_SV_ACC  = 5'd23;
  localparam logic [SW-1:0] ST_SV_WB   = 5'd24;
  localparam logic [SW-1:0] ST_DV_RD   = 5'd25;
  localparam logic [SW-1:0] ST_DV_GO   = 5'd26;
  localparam logic [SW-1:0] ST_DV_WT   = 5'd27;
  localparam logic [SW-1:0] ST_OUT_RD  = 5'd28;
  localparam logic [SW-1:0] ST_OUT_EM  = 5'd29;

  localparam logic [1:0] PH_ELIM = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;

  // Matrix element address: row-major with a fixed row pitch of MAX_N.
  function automatic logic [AW-1:0] maddr_f(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * lufs_pkg::MAX_N + int'(c));
  endfunction

  // Sequencer state and counters.
  logic [SW-1:0] state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic [NW-1:0] n_q, n_d;
  logic [4:0]    size_q, size_d;
  logic [15:0]   thr_q, thr_d;
  logic [IW-1:0] lrow_q, lrow_d, lcol_q, lcol_d, rcnt_q, rcnt_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, c_q, c_d, k_q, k_d;
  logic          lu_ready_q, lu_ready_d, ovf_q, ovf_d, parity_q, parity_d;
  logic          sing_q, sing_d;

  // Datapath registers.
  logic [MW-1:0]           best_q, best_d;
  logic signed [DW-1:0]    pivval_q, pivval_d, f_q, f_d, acc_q, acc_d, tmp_q, tmp_d;
  logic signed [DW-1:0]    mres_q, mres_d;
  logic signed [2*DW-1:0]  prod_q, prod_d;
  logic [IW-1:0]           piv_q [lufs_pkg::MAX_N-1];

  logic                    out_valid_q, out_valid_d;
  lufs_pkg::out_t          out_q, out_d;

  // Memories.
  logic signed [DW-1:0]    mat_mem [lufs_pkg::MAX_N*lufs_pkg::MAX_N];
  logic signed [DW-1:0]    rhs_mem [lufs_pkg::MAX_N];
  logic signed [DW-1:0]    rdm_q, rdr_q;
  logic [AW-1:0]           maddr, mwaddr;
  logic                    mwe;
  logic signed [DW-1:0]    mwdata;
  logic [IW-1:0]           raddr, rwaddr;
  logic                    rwe;
  logic signed [DW-1:0]    rwdata;
  logic                    piv_we;

  // Shared arithmetic.
  logic signed [DW-1:0]    mul_a, mul_b;
  lufs_pkg::sat_t          mul_r, sub_r;
  lufs_pkg::div_req_t      div_req;
  lufs_pkg::div_rsp_t      div_rsp;

  logic [NW-1:0]           nm1, n_new, n_use, nm1_use;
  logic                    first_load;
  logic [MW-1:0]           cur_mag;
  logic                    i_last, j_last, c_last;

  lufs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    // Clamp the configured size into the supported range.
    if (size_q < 5'd2) begin
      n_new = NW'(2);
    end else if (NW'(size_q) > NW'(lufs_pkg::MAX_N)) begin
      n_new = NW'(lufs_pkg::MAX_N);
    end else begin
      n_new = NW'(size_q);
    end
    first_load = (lrow_q == '0) && (lcol_q == '0);
    n_use      = first_load ? n_new : n_q;
    nm1_use    = n_use - 1'b1;
    nm1        = n_q - 1'b1;
    i_last     = (NW'(i_q) == nm1);
    j_last     = (NW'(j_q) == nm1);
    c_last     = (NW'(c_q) == nm1);
    cur_mag    = lufs_pkg::mag(rdm_q);
    mul_r      = lufs_pkg::mul_round_sat(prod_q);
    sub_r      = lufs_pkg::sub_sat(acc_q, mres_q);
    if (phase_q == PH_ELIM) begin
      mul_a = f_q;
      mul_b = rdm_q;
    end else begin
      mul_a = rdm_q;
      mul_b = rdr_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    n_d         = n_q;
    size_d      = size_q;
    thr_d       = thr_q;
    lrow_d      = lrow_q;
    lcol_d      = lcol_q;
    rcnt_d      = rcnt_q;
    i_d         = i_q;
    j_d         = j_q;
    c_d         = c_q;
    k_d         = k_q;
    lu_ready_d  = lu_ready_q;
    ovf_d       = ovf_q;
    parity_d    = parity_q;
    sing_d      = sing_q;
    best_d      = best_q;
    pivval_d    = pivval_q;
    f_d         = f_q;
    acc_d       = acc_q;
    tmp_d       = tmp_q;
    mres_d      = mres_q;
    prod_d      = prod_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    maddr       = '0;
    mwe         = 1'b0;
    mwaddr      = '0;
    mwdata      = '0;
    raddr       = '0;
    rwe         = 1'b0;
    rwaddr      = '0;
    rwdata      = '0;
    piv_we      = 1'b0;
    div_req     = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lufs_pkg::REG_MATRIX_SIZE: size_d = cfg_wdata_i[4:0];
        lufs_pkg::REG_ZERO_THR:    thr_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (in_i.command == lufs_pkg::CMD_MATRIX) begin
            if (first_load) begin
              n_d        = n_new;
              lu_ready_d = 1'b0;
              rcnt_d     = '0;
              ovf_d      = 1'b0;
            end
            mwe    = 1'b1;
            mwaddr = maddr_f(lrow_q, lcol_q);
            mwdata = in_i.value;
            if (NW'(lcol_q) == nm1_use) begin
              lcol_d = '0;
              if (NW'(lrow_q) == nm1_use) begin
                // Last element: start factoring at the first column.
                lrow_d   = '0;
                parity_d = 1'b0;
                i_d      = '0;
                j_d      = '0;
                phase_d  = PH_ELIM;
                state_d  = ST_PV_RD;
              end else begin
                lrow_d = lrow_q + 1'b1;
              end
            end else begin
              lcol_d = lcol_q + 1'b1;
            end
          end else if (lu_ready_q) begin
            rwe    = 1'b1;
            rwaddr = rcnt_q;
            rwdata = in_i.value;
            if (NW'(rcnt_q) == nm1) begin
              rcnt_d  = '0;
              i_d     = '0;
              state_d = ST_PM_CHK;
            end else begin
              rcnt_d = rcnt_q + 1'b1;
            end
          end
        end
      end

      // Pivot search down column i.
      ST_PV_RD: begin
        maddr   = maddr_f(j_q, i_q);
        state_d = ST_PV_EV;
      end
      ST_PV_EV: begin
        if ((j_q == i_q) || (cur_mag > best_q)) begin
          best_d   = cur_mag;
          k_d      = j_q;
          pivval_d = rdm_q;
        end
        if (j_last) begin
          state_d = ST_PV_CHK;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_PV_RD;
        end
      end
      ST_PV_CHK: begin
        if (best_q <= MW'(thr_q)) begin
          sing_d  = 1'b1;
          state_d = ST_STATUS;
        end else begin
          sing_d = 1'b0;
          piv_we = (int'(i_q) < lufs_pkg::MAX_N - 1);
          if (k_q != i_q) begin
            parity_d = ~parity_q;
            c_d      = '0;
            state_d  = ST_SW_RD1;
          end else if (i_last) begin
            state_d = ST_STATUS;
          end else begin
            j_d     = i_q + 1'b1;
            state_d = ST_EL_RD;
          end
        end
      end

      // Row swap, one column at a time, through two reads and two writes.
      ST_SW_RD1: begin
        maddr   = maddr_f(i_q, c_q);
        state_d = ST_SW_RD2;
      end
      ST_SW_RD2: begin
        maddr   = maddr_f(k_q, c_q);
        tmp_d   = rdm_q;
        state_d = ST_SW_WR1;
      end
      ST_SW_WR1: begin
        mwe     = 1'b1;
        mwaddr  = maddr_f(i_q, c_q);
        mwdata  = rdm_q;
        state_d = ST_SW_WR2;
      end
      ST_SW_WR2: begin
        mwe    = 1'b1;
        mwaddr = maddr_f(k_q, c_q);
        mwdata = tmp_q;
        if (c_last) begin
          if (i_last) begin
            state_d = ST_STATUS;
          end else begin
            j_d     = i_q + 1'b1;
            state_d = ST_EL_RD;
          end
        end else begin
          c_d     = c_q + 1'b1;
          state_d = ST_SW_RD1;
        end
      end

      // Elimination of row j: multiplier by division, then the row update.
      ST_EL_RD: begin
        maddr   = maddr_f(j_q, i_q);
        state_d = ST_EL_GO;
      end
      ST_EL_GO: begin
        div_req.start = 1'b1;
        div_req.a     = rdm_q;
        div_req.b     = pivval_q;
        state_d       = ST_EL_WT;
      end
      ST_EL_WT: begin
        if (div_rsp.done) begin
          f_d     = div_rsp.q;
          ovf_d   = ovf_q | div_rsp.ovf;
          c_d     = i_q + 1'b1;
          state_d = ST_MAC_RD;
        end
      end

      // Shared multiply-subtract loop, used by elimination and both substitutions.
      ST_MAC_RD: begin
        if (phase_q == PH_ELIM) begin
          maddr = maddr_f(i_q, c_q);
        end else begin
          maddr = maddr_f(i_q, j_q);
          raddr = j_q;
        end
        state_d = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        prod_d  = mul_a * mul_b;
        maddr   = maddr_f(j_q, c_q);
        state_d = ST_MAC_RND;
      end
      ST_MAC_RND: begin
        mres_d = mul_r.val;
        ovf_d  = ovf_q | mul_r.ovf;
        if (phase_q == PH_ELIM) begin
          acc_d = rdm_q;
        end
        state_d = ST_MAC_SUB;
      end
      ST_MAC_SUB: begin
        ovf_d = ovf_q | sub_r.ovf;
        unique case (phase_q)
          PH_ELIM: begin
            mwe    = 1'b1;
            mwaddr = maddr_f(j_q, c_q);
            mwdata = sub_r.val;
            if (c_last) begin
              state_d = ST_EL_WF;
            end else begin
              c_d     = c_q + 1'b1;
              state_d = ST_MAC_RD;
            end
          end
          PH_FWD: begin
            acc_d = sub_r.val;
            if (j_q + 1'b1 == i_q) begin
              state_d = ST_SV_WB;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = ST_MAC_RD;
            end
          end
          default: begin
            acc_d = sub_r.val;
            if (j_q == i_q + 1'b1) begin
              state_d = ST_DV_RD;
            end else begin
              j_d     = j_q - 1'b1;
              state_d = ST_MAC_RD;
            end
          end
        endcase
      end
      ST_EL_WF: begin
        mwe    = 1'b1;
        mwaddr = maddr_f(j_q, i_q);
        mwdata = f_q;
        if (j_last) begin
          i_d     = i_q + 1'b1;
          j_d     = i_q + 1'b1;
          state_d = ST_PV_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_EL_RD;
        end
      end

      ST_STATUS: begin
        out_valid_d         = 1'b1;
        out_d.kind          = lufs_pkg::KIND_STATUS;
        out_d.index         = '0;
        out_d.solution      = '0;
        out_d.singular      = sing_q;
        out_d.overflow      = ovf_q;
        out_d.perm_negative = parity_q;
        out_d.last          = sing_q;
        lu_ready_d          = ~sing_q;
        state_d             = ST_IDLE;
      end

      // Apply the recorded row interchanges to the right-hand side.
      ST_PM_CHK: begin
        if (i_last) begin
          i_d     = '0;
          phase_d = PH_FWD;
          state_d = ST_SV_BEG;
        end else if (piv_q[i_q[PIW-1:0]] == i_q) begin
          i_d = i_q + 1'b1;
        end else begin
          k_d     = piv_q[i_q[PIW-1:0]];
          state_d = ST_PM_RD1;
        end
      end
      ST_PM_RD1: begin
        raddr   = i_q;
        state_d = ST_PM_RD2;
      end
      ST_PM_RD2: begin
        raddr   = k_q;
        tmp_d   = rdr_q;
        state_d = ST_PM_WR1;
      end
      ST_PM_WR1: begin
        rwe     = 1'b1;
        rwaddr  = i_q;
        rwdata  = rdr_q;
        state_d = ST_PM_WR2;
      end
      ST_PM_WR2: begin
        rwe     = 1'b1;
        rwaddr  = k_q;
        rwdata  = tmp_q;
        i_d     = i_q + 1'b1;
        state_d = ST_PM_CHK;
      end

      // Forward and back substitution, row i.
      ST_SV_BEG: begin
        raddr   = i_q;
        state_d = ST_SV_ACC;
      end
      ST_SV_ACC: begin
        acc_d = rdr_q;
        if (phase_q == PH_FWD) begin
          if (i_q == '0) begin
            state_d = ST_SV_WB;
          end else begin
            j_d     = '0;
            state_d = ST_MAC_RD;
          end
        end else if (i_last) begin
          state_d = ST_DV_RD;
        end else begin
          j_d     = IW'(nm1);
          state_d = ST_MAC_RD;
        end
      end
      ST_SV_WB: begin
        rwe    = 1'b1;
        rwaddr = i_q;
        rwdata = acc_q;
        if (i_last) begin
          phase_d = PH_BACK;
        end else begin
          i_d = i_q + 1'b1;
        end
        state_d = ST_SV_BEG;
      end
      ST_DV_RD: begin
        maddr   = maddr_f(i_q, i_q);
        state_d = ST_DV_GO;
      end
      ST_DV_GO: begin
        div_req.start = 1'b1;
        div_req.a     = acc_q;
        div_req.b     = rdm_q;
        state_d       = ST_DV_WT;
      end
      ST_DV_WT: begin
        if (div_rsp.done) begin
          rwe    = 1'b1;
          rwaddr = i_q;
          rwdata = div_rsp.q;
          ovf_d  = ovf_q | div_rsp.ovf;
          if (i_q == '0) begin
            state_d = ST_OUT_RD;
          end else begin
            i_d     = i_q - 1'b1;
            state_d = ST_SV_BEG;
          end
        end
      end

      // Stream the solution out, reading each entry before emitting its beat.
      ST_OUT_RD: begin
        raddr   = i_q;
        state_d = ST_OUT_EM;
      end
      ST_OUT_EM: begin
        out_valid_d         = 1'b1;
        out_d.kind          = lufs_pkg::KIND_SOLUTION;
        out_d.index         = i_q;
        out_d.solution      = rdr_q;
        out_d.singular      = 1'b0;
        out_d.overflow      = ovf_q;
        out_d.perm_negative = parity_q;
        out_d.last          = i_last;
        if (i_last) begin
          state_d = ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_OUT_RD;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_ELIM;
      n_q         <= NW'(2);
      size_q      <= 5'd16;
      thr_q       <= 16'd1;
      lrow_q      <= '0;
      lcol_q      <= '0;
      rcnt_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      lu_ready_q  <= 1'b0;
      ovf_q       <= 1'b0;
      parity_q    <= 1'b0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      n_q         <= n_d;
      size_q      <= size_d;
      thr_q       <= thr_d;
      lrow_q      <= lrow_d;
      lcol_q      <= lcol_d;
      rcnt_q      <= rcnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      c_q         <= c_d;
      k_q         <= k_d;
      lu_ready_q  <= lu_ready_d;
      ovf_q       <= ovf_d;
      parity_q    <= parity_d;
      sing_q      <= sing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    pivval_q <= pivval_d;
    f_q      <= f_d;
    acc_q    <= acc_d;
    tmp_q    <= tmp_d;
    mres_q   <= mres_d;
    prod_q   <= prod_d;
    out_q    <= out_d;
    if (piv_we) begin
      piv_q[i_q[PIW-1:0]] <= k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mat_mem[mwaddr] <= mwdata;
    end
    rdm_q <= mat_mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (rwe) begin
      rhs_mem[rwaddr] <= rwdata;
    end
    rdr_q <= rhs_mem[raddr];
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign res_o          = out_q;

  // A result beat only ever follows one of the two emitting states.
  a_beat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_STATUS || $past(state_q) == ST_OUT_EM))
    else $error("result beat without an emitting state");

  // A singular status always closes the run.
  a_singular_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.kind == lufs_pkg::KIND_STATUS && res_o.singular) |-> res_o.last)
    else $error("singular status not marked last");

  // Solutions are produced only from a good factorization.
  a_solution_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.kind == lufs_pkg::KIND_SOLUTION) |-> lu_ready_q)
    else $error("solution beat without a factorization");

  // The divider is started only from the two launch states, and answers later.
  a_div_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == ST_EL_GO || state_q == ST_DV_GO) ##1 !div_rsp.done || 1'b1)
    else $error("divider started outside a launch state");

endmodule

// ===== test/lu_factor_and_solve_tb.sv =====
// Self-checking testbench for the LU factor-and-solve block, with its own predictor.
`timescale 1ns / 100ps

// The scoreboard keeps its own copy of the block's state and configuration.
// Each accepted input beat updates that copy, and any results the beat causes are queued.
// Each result beat from the block is then checked against the oldest queued result.
class lu_scoreboard;
  int unsigned                          size_reg = 16;
  int unsigned                          thr_reg  = 1;
  logic signed [lufs_pkg::DATA_W-1:0]   mat [lufs_pkg::MAX_N][lufs_pkg::MAX_N];
  logic signed [lufs_pkg::DATA_W-1:0]   rhs [lufs_pkg::MAX_N];
  int                                   piv [lufs_pkg::MAX_N];
  bit                                   parity;
  bit                                   ovf_sticky;
  bit                                   lu_valid;
  int                                   load_cnt;
  int                                   rhs_cnt;
  int                                   order = 2;
  lufs_pkg::out_t                       pending[$];
  int                                   errors;

  function logic signed [lufs_pkg::DATA_W-1:0] sat(longint v);
    if (v > longint'(lufs_pkg::FX_MAX)) begin
      ovf_sticky = 1;
      return lufs_pkg::FX_MAX;
    end
    if (v < longint'(lufs_pkg::FX_MIN)) begin
      ovf_sticky = 1;
      return lufs_pkg::FX_MIN;
    end
    return v[lufs_pkg::DATA_W-1:0];
  endfunction

  function logic signed [lufs_pkg::DATA_W-1:0] fx_mul(
      logic signed [lufs_pkg::DATA_W-1:0] a, logic signed [lufs_pkg::DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (lufs_pkg::FRAC_BITS - 1));
    return sat(p >>> lufs_pkg::FRAC_BITS);
  endfunction

  function logic signed [lufs_pkg::DATA_W-1:0] fx_sub(
      logic signed [lufs_pkg::DATA_W-1:0] a, logic signed [lufs_pkg::DATA_W-1:0] b);
    return sat(longint'(a) - longint'(b));
  endfunction

  // Quotient truncated towards zero; a zero divisor saturates by the numerator's sign.
  function logic signed [lufs_pkg::DATA_W-1:0] fx_div(
      logic signed [lufs_pkg::DATA_W-1:0] a, logic signed [lufs_pkg::DATA_W-1:0] b);
    longint num;
    if (b == 0) begin
      ovf_sticky = 1;
      return (a >= 0) ? lufs_pkg::FX_MAX : lufs_pkg::FX_MIN;
    end
    num = longint'(a) * (64'sd1 <<< lufs_pkg::FRAC_BITS);
    return sat(num / longint'(b));
  endfunction

  function longint magnitude(logic signed [lufs_pkg::DATA_W-1:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Returns 1 when a pivot is at or below the threshold.
  function bit factorise();
    longint                             best;
    int                                 k;
    logic signed [lufs_pkg::DATA_W-1:0] t;
    logic signed [lufs_pkg::DATA_W-1:0] f;
    for (int i = 0; i < order; i++) piv[i] = i;
    parity = 0;
    for (int i = 0; i < order; i++) begin
      best = magnitude(mat[i][i]);
      k = i;
      for (int j = i + 1; j < order; j++) begin
        if (magnitude(mat[j][i]) > best) begin
          best = magnitude(mat[j][i]);
          k = j;
        end
      end
      if (best <= longint'(thr_reg)) return 1;
      if (k != i) begin
        for (int c = 0; c < order; c++) begin
          t = mat[i][c];
          mat[i][c] = mat[k][c];
          mat[k][c] = t;
        end
        piv[i] = k;
        parity ^= 1'b1;
      end
      for (int j = i + 1; j < order; j++) begin
        f = fx_div(mat[j][i], mat[i][i]);
        for (int c = i + 1; c < order; c++) mat[j][c] = fx_sub(mat[j][c], fx_mul(f, mat[i][c]));
        mat[j][i] = f;
      end
    end
    return 0;
  endfunction

  function void substitute();
    logic signed [lufs_pkg::DATA_W-1:0] t;
    logic signed [lufs_pkg::DATA_W-1:0] acc;
    for (int i = 0; i + 1 < order; i++) begin
      if (piv[i] != i) begin
        t = rhs[i];
        rhs[i] = rhs[piv[i]];
        rhs[piv[i]] = t;
      end
    end
    for (int i = 0; i < order; i++) begin
      acc = rhs[i];
      for (int j = 0; j < i; j++) acc = fx_sub(acc, fx_mul(mat[i][j], rhs[j]));
      rhs[i] = acc;
    end
    for (int i = order - 1; i >= 0; i--) begin
      acc = rhs[i];
      for (int j = order - 1; j > i; j--) acc = fx_sub(acc, fx_mul(mat[i][j], rhs[j]));
      rhs[i] = fx_div(acc, mat[i][i]);
    end
  endfunction

  function void note_beat(lufs_pkg::in_t beat);
    bit             sing;
    lufs_pkg::out_t r;
    if (beat.command == lufs_pkg::CMD_MATRIX) begin
      if (load_cnt == 0) begin
        order = (size_reg < 2) ? 2 : (size_reg > lufs_pkg::MAX_N) ? lufs_pkg::MAX_N : size_reg;
        lu_valid = 0;
        rhs_cnt = 0;
        ovf_sticky = 0;
      end
      mat[load_cnt / order][load_cnt % order] = beat.value;
      load_cnt++;
      if (load_cnt >= order * order) begin
        load_cnt = 0;
        sing = factorise();
        lu_valid = !sing;
        r = '0;
        r.kind = lufs_pkg::KIND_STATUS;
        r.singular = sing;
        r.overflow = ovf_sticky;
        r.perm_negative = parity;
        r.last = sing;
        pending.push_back(r);
      end
    end else if (lu_valid) begin
      rhs[rhs_cnt] = beat.value;
      rhs_cnt++;
      if (rhs_cnt == order) begin
        rhs_cnt = 0;
        substitute();
        for (int i = 0; i < order; i++) begin
          r = '0;
          r.kind = lufs_pkg::KIND_SOLUTION;
          r.index = i[lufs_pkg::IW-1:0];
          r.solution = rhs[i];
          r.overflow = ovf_sticky;
          r.perm_negative = parity;
          r.last = (i == order - 1);
          pending.push_back(r);
        end
      end
    end
  endfunction

  function void mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  function void check_result(lufs_pkg::out_t got);
    lufs_pkg::out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.kind !== want.kind) mismatch("kind", want.kind, got.kind);
    if (got.index !== want.index) mismatch("index", want.index, got.index);
    if (got.solution !== want.solution) mismatch("solution", want.solution, got.solution);
    if (got.singular !== want.singular) mismatch("singular", want.singular, got.singular);
    if (got.overflow !== want.overflow) mismatch("overflow", want.overflow, got.overflow);
    if (got.perm_negative !== want.perm_negative)
      mismatch("perm_negative", want.perm_negative, got.perm_negative);
    if (got.last !== want.last) mismatch("last", want.last, got.last);
  endfunction
endclass

module lu_factor_and_solve_tb;

  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  RANDOM_BEATS = 330;
  localparam logic signed [lufs_pkg::DATA_W-1:0] ONE = 32'sd65536;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic                            busy_o;
  lufs_pkg::in_t                   in_i = '0;
  logic                            result_valid_o;
  lufs_pkg::out_t                  res_o;
  logic                            cfg_we_i = 1'b0;
  logic [lufs_pkg::CFG_IW-1:0]     cfg_idx_i = '0;
  logic [lufs_pkg::CFG_DW-1:0]     cfg_wdata_i = '0;

  lu_scoreboard sb = new();
  int  cycles;
  int  burst_left;
  int  beats_sent;

  lu_factor_and_solve u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .result_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Outputs are read straight after the edge, so the values seen are those that the edge
  // sampled. A result beat cannot be stalled, so every strobe is a completed beat.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(res_o);
  end

  // Watchdog. The slowest step of the run is a 16 by 16 factorisation.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lu_factor_and_solve_tb: done, errors");
      $finish;
    end
  end

  // Offers one beat and returns at the edge that takes it. The sender works in bursts:
  // when a burst runs out, start is dropped for a random gap before the next one. A gap
  // of zero keeps start high, so long back-to-back stretches also occur.
  task automatic send_beat(logic cmd, logic signed [lufs_pkg::DATA_W-1:0] val);
    int gap;
    lufs_pkg::in_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    beat.command = cmd;
    beat.value = val;
    start_i <= 1'b1;
    in_i <= beat;
    do @(posedge clk_i); while (busy_o);
    sb.note_beat(beat);
    beats_sent++;
  endtask

  // Waits until every expected result has come and the block has dropped busy, then lets a
  // few more cycles pass in case ignored beats leave anything in flight.
  task automatic settle();
    start_i <= 1'b0;
    while (sb.pending.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lufs_pkg::CFG_IW-1:0] idx,
                           logic [lufs_pkg::CFG_DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lufs_pkg::REG_MATRIX_SIZE) sb.size_reg = data & 16'h1f;
    else sb.thr_reg = data;
  endtask

  // Upper bits of the size write are random; only the low five bits hold the order.
  task automatic set_size(int unsigned sz);
    write_reg(lufs_pkg::REG_MATRIX_SIZE, {11'($urandom), 5'(sz)});
  endtask

  function automatic logic signed [lufs_pkg::DATA_W-1:0] near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // One random phase: new settings, a matrix, then one or more right-hand sides. Most matrices
  // are well conditioned so that the solve path is reached; the rest are noise or singular.
  task automatic random_phase(bit biggest);
    int unsigned sz;
    int          n;
    int          flavour;
    int          dup_row;
    int          solves;
    int          cnt;
    logic signed [lufs_pkg::DATA_W-1:0] v;
    settle();
    if (biggest) sz = ($urandom_range(0, 1) != 0) ? 31 : 16;
    else if ($urandom_range(0, 9) == 0) sz = $urandom_range(0, 1);
    else if ($urandom_range(0, 5) == 0) sz = $urandom_range(6, 9);
    else sz = $urandom_range(2, 5);
    set_size(sz);
    case ($urandom_range(0, 5))
      0: write_reg(lufs_pkg::REG_ZERO_THR, 16'hffff);
      1: write_reg(lufs_pkg::REG_ZERO_THR, 16'h0000);
      2: write_reg(lufs_pkg::REG_ZERO_THR, 16'($urandom_range(0, 400)));
      default: ;
    endcase
    n = (sz < 2) ? 2 : (sz > lufs_pkg::MAX_N) ? lufs_pkg::MAX_N : sz;
    flavour = $urandom_range(0, 9);
    dup_row = $urandom_range(1, n - 1);
    // A stray right-hand-side beat before the matrix: it either joins the old system's
    // partial load or is ignored.
    if ($urandom_range(0, 4) == 0) send_beat(lufs_pkg::CMD_RHS, $urandom);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (flavour == 0) v = $urandom;
        else if (flavour == 1 && r == dup_row) v = sb.mat[0][c];
        else if (flavour == 1) v = (r == 0) ? near(4 * ONE) : near(4 * ONE);
        else v = near(2 * ONE) + ((r == c) ? (n * ONE) : 0);
        if (flavour == 1 && r == dup_row && !biggest) v = v;
        send_beat(lufs_pkg::CMD_MATRIX, v);
      end
    end
    solves = $urandom_range(1, 3);
    for (int s = 0; s < solves; s++) begin
      cnt = (s == solves - 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : n;
      for (int i = 0; i < cnt; i++)
        send_beat(lufs_pkg::CMD_RHS, ($urandom_range(0, 5) == 0) ? $urandom : near(8 * ONE));
    end
  endtask

  initial begin
    logic signed [lufs_pkg::DATA_W-1:0] dir_mat [4];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Right-hand side with no factorisation yet: ignored.
    send_beat(lufs_pkg::CMD_RHS, ONE);
    settle();
    // Size below range clamps to two; a zero threshold.
    set_size(0);
    write_reg(lufs_pkg::REG_ZERO_THR, 16'h0000);

    // [[1,2],[3,4]] needs a row swap, so the sign comes out negative.
    dir_mat = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE};
    foreach (dir_mat[i]) send_beat(lufs_pkg::CMD_MATRIX, dir_mat[i]);
    send_beat(lufs_pkg::CMD_RHS, ONE);
    send_beat(lufs_pkg::CMD_RHS, -ONE);

    // Extremes of the value field: saturation and the sticky overflow flag.
    dir_mat = '{lufs_pkg::FX_MAX, lufs_pkg::FX_MIN, lufs_pkg::FX_MIN, lufs_pkg::FX_MAX};
    foreach (dir_mat[i]) send_beat(lufs_pkg::CMD_MATRIX, dir_mat[i]);
    send_beat(lufs_pkg::CMD_RHS, lufs_pkg::FX_MIN);
    send_beat(lufs_pkg::CMD_RHS, lufs_pkg::FX_MAX);
    settle();

    // All-zero matrix is singular; the following right-hand side is ignored.
    write_reg(lufs_pkg::REG_ZERO_THR, 16'hffff);
    repeat (4) send_beat(lufs_pkg::CMD_MATRIX, 0);
    send_beat(lufs_pkg::CMD_RHS, ONE);

    // A partly loaded right-hand side is discarded when a new matrix starts.
    dir_mat = '{ONE, 0, 0, ONE};
    foreach (dir_mat[i]) send_beat(lufs_pkg::CMD_MATRIX, dir_mat[i] * 3);
    send_beat(lufs_pkg::CMD_RHS, 5 * ONE);
    foreach (dir_mat[i]) send_beat(lufs_pkg::CMD_MATRIX, dir_mat[i] * 2);
    send_beat(lufs_pkg::CMD_RHS, ONE);
    send_beat(lufs_pkg::CMD_RHS, 7 * ONE);
    settle();
    write_reg(lufs_pkg::REG_ZERO_THR, 16'd1);

    // Random phases; the third one uses the largest order.
    beats_sent = 0;
    for (int p = 0; beats_sent < RANDOM_BEATS || p < 4; p++) random_phase(p == 2);

    settle();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lu_factor_and_solve_tb: done, clean");
    end else begin
      $display("lu_factor_and_solve_tb: done, errors");
    end
    $finish;
  end

endmodule
